FILE: sv/plist_pkg.sv
// Shared types, codes and defaults for the positional list engine.
package plist_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned POS_W = 8;
	localparam int unsigned LEN_W = 5;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_INVALID = 2'd1,
		STS_EMPTY   = 2'd2,
		STS_FULL    = 2'd3
	} status_e_t;

	typedef enum logic [1:0] {
		K_DONE = 2'd0,
		K_INS  = 2'd1,
		K_DEL  = 2'd2,
		K_READ = 2'd3
	} kind_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_SHIFT_WR,
		S_PLACE,
		S_RESP
	} state_e_t;

	typedef struct packed {
		op_e_t                    operation;
		logic [POS_W-1:0]         position;
		logic signed [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_e_t                status;
		logic signed [VAL_W-1:0]  read_value;
		logic [LEN_W-1:0]         length;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic wr_move;
		logic wr_val;
		logic commit;
	} plist_cmd_t;

	typedef struct packed {
		kind_e_t kind;
		logic    more;
		logic    out_free;
	} plist_sts_t;

endpackage

FILE: sv/plist_ctrl.sv
// Controller state machine that sequences request decode, entry moves and the result beat.
module plist_ctrl
	import plist_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  plist_sts_t sts,
	output plist_cmd_t cmd
);

	state_e_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_STEP;
			end
			S_STEP: begin
				unique case (sts.kind)
					K_DONE: state_d = S_RESP;
					K_READ: state_d = S_RESP;
					K_INS:  state_d = sts.more ? S_SHIFT_WR : S_PLACE;
					K_DEL:  state_d = sts.more ? S_SHIFT_WR : S_RESP;
				endcase
			end
			S_SHIFT_WR: state_d = S_STEP;
			S_PLACE:    state_d = S_RESP;
			S_RESP: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			S_STEP: begin
				// A read request fetches its entry; a shift fetches the next entry to move.
				cmd.rd_en = (sts.kind == K_READ) ||
					(((sts.kind == K_INS) || (sts.kind == K_DEL)) && sts.more);
			end
			S_SHIFT_WR: cmd.wr_move = 1'b1;
			S_PLACE:    cmd.wr_val  = 1'b1;
			S_RESP:     cmd.commit  = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: sv/plist_dp.sv
// Datapath: entry memory, count, request registers, move pointer and result register.
module plist_dp
	import plist_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  plist_cmd_t cmd,
	output plist_sts_t sts
);

	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [VAL_W-1:0] mem [DEPTH];

	logic [CW-1:0]           count_q, count_d;
	kind_e_t                 kind_q, kind_d;
	status_e_t               status_q, status_d;
	logic [AW-1:0]           idx_q, idx_d;
	logic [AW-1:0]           ptr_q, ptr_d;
	logic signed [VAL_W-1:0] val_q;
	logic [VAL_W-1:0]        rdata_q;
	rsp_t                    out_q;
	logic                    out_valid_q;

	logic [CMPW-1:0] pos_x, n_x, pm1_x, ptr_x, cnt_x;
	logic            pos_zero, full, empty;
	logic [AW-1:0]   src, rd_addr, wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic            we;
	logic            more;
	logic            out_free;

	assign pos_x    = CMPW'(req.position);
	assign n_x      = CMPW'(count_q);
	assign pm1_x    = pos_x - CMPW'(1);
	assign pos_zero = (req.position == '0);
	assign full     = (n_x == CMPW'(DEPTH));
	assign empty    = (count_q == '0);

	// Decode the request against the current length when the beat is taken.
	always_comb begin
		status_d = STS_OK;
		kind_d   = K_DONE;
		idx_d    = pm1_x[AW-1:0];
		ptr_d    = count_q[AW-1:0];
		unique case (req.operation)
			OP_APPEND: begin
				idx_d = count_q[AW-1:0];
				if (full) status_d = STS_FULL;
				else      kind_d   = K_INS;
			end
			OP_INSERT: begin
				if (full)                                     status_d = STS_FULL;
				else if (pos_zero || (pos_x > n_x + CMPW'(1))) status_d = STS_INVALID;
				else                                          kind_d   = K_INS;
			end
			OP_DELETE: begin
				ptr_d = pm1_x[AW-1:0];
				if (empty)                         status_d = STS_EMPTY;
				else if (pos_zero || (pos_x > n_x)) status_d = STS_INVALID;
				else                               kind_d   = K_DEL;
			end
			OP_READ: begin
				if (pos_zero || (pos_x > n_x)) status_d = STS_INVALID;
				else                          kind_d   = K_READ;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			status_q <= status_d;
			idx_q    <= idx_d;
			val_q    <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= K_DONE;
			ptr_q  <= '0;
		end else if (cmd.capture) begin
			kind_q <= kind_d;
			ptr_q  <= ptr_d;
		end else if (cmd.wr_move) begin
			ptr_q  <= src;
		end
	end

	// Inserts walk from the tail toward the insert point; deletes walk toward the tail.
	assign ptr_x = CMPW'(ptr_q);
	always_comb begin
		if (kind_q == K_DEL) begin
			src  = ptr_q + AW'(1);
			more = (ptr_x + CMPW'(1)) < n_x;
		end else begin
			src  = ptr_q - AW'(1);
			more = ptr_q > idx_q;
		end
	end

	assign rd_addr = (kind_q == K_READ) ? idx_q : src;
	assign we      = cmd.wr_move | cmd.wr_val;
	assign wr_addr = cmd.wr_val ? idx_q : ptr_q;
	assign wr_data = cmd.wr_val ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rdata_q <= mem[rd_addr];
	end

	always_comb begin
		count_d = count_q;
		if (status_q == STS_OK) begin
			if (kind_q == K_INS)      count_d = count_q + CW'(1);
			else if (kind_q == K_DEL) count_d = count_q - CW'(1);
		end
	end
	assign cnt_x = CMPW'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.status     <= status_q;
			out_q.read_value <= (kind_q == K_READ) ? rdata_q : '0;
			out_q.length     <= cnt_x[LEN_W-1:0];
		end
	end

	assign out_free  = !out_valid_q || !rsp_stall;
	assign sts       = {kind_q, more, out_free};
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: sv/positional_list_engine.sv
// Request beat to result beat: read, error and full/empty replies go from S_STEP straight to S_RESP;
// append and insert move k entries, then write the new value in S_PLACE; delete moves k entries.
// Each moved entry takes one memory read in S_STEP and one write in S_SHIFT_WR.
// A new request is taken the cycle after the previous result is loaded into the output register.
// Reset clears the length to zero (empty list); stored entry contents are not cleared.
module positional_list_engine
	import plist_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	plist_cmd_t cmd;
	plist_sts_t sts;

	plist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	plist_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
